// ----- design/assert_macros.svh -----
// assertion helpers included by the core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/mbt_pkg.sv -----
`timescale 1ns / 1ps
package mbt_pkg;

  // table size and internal resolution
  localparam int MAX_SEGMENTS = 16;
  localparam int INTERNAL_RES = 480;
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);

  // field widths
  localparam int TICK_W     = 31;
  localparam int TPQ_W      = 15;
  localparam int MEAS_W     = 20;
  localparam int BEAT_W     = 8;
  localparam int STICK_W    = 16;
  localparam int PRE_W      = 32;
  localparam int NUM_W      = 8;
  localparam int DLOG_W     = 3;
  localparam int CPC_W      = 8;
  localparam int BEAT_LEN_W = 20;
  localparam int MEAS_LEN_W = 26;
  localparam int RES_W      = $clog2(INTERNAL_RES + 1);

  // shared divider sizes
  localparam int DIV_W     = TICK_W + RES_W;
  localparam int DVS_W     = MEAS_LEN_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // musical constants
  localparam int CLOCKS_PER_QUARTER = 24;
  localparam int QUARTERS_PER_WHOLE = 4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EVENT = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_PRE_BAR  = 3'd1,
    STS_FULL     = 3'd2,
    STS_ZERO_LEN = 3'd3,
    STS_ORDER    = 3'd4
  } status_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- design/mbt_div.sv -----
`timescale 1ns / 1ps
module mbt_div (
  input  logic              clk,
  input  logic              rst,
  input  mbt_pkg::div_req_t req,
  output mbt_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic [mbt_pkg::DIV_CNT_W-1:0]  cnt;
  logic [mbt_pkg::DIV_W-1:0]      quo;
  logic [mbt_pkg::DVS_W-1:0]      rem;
  logic [mbt_pkg::DVS_W-1:0]      dvs;
  logic                           done;
  logic [mbt_pkg::DVS_W:0]        trial;
  logic                           fits;

  // one restoring step per cycle while busy
  assign trial = {rem, quo[mbt_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= mbt_pkg::DIV_CNT_W'(mbt_pkg::DIV_W);
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= mbt_pkg::DVS_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[mbt_pkg::DVS_W-1:0];
        end
        quo <= {quo[mbt_pkg::DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == mbt_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ----- design/measure_beat_tick_position_core.sv -----
`timescale 1ns / 1ps
// clear: result through S_FINISH once the output register is free; unknown opcode likewise
// event: up to two passes of the bit-serial divider
// query: a scan of up to 16 segments plus three divider passes; one pass before measure one
// one item at a time; input ready again as soon as the result register loads
// rst (synchronous) sets resolution 480, offset 0 and a single 4/4 segment
module measure_beat_tick_position_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [55:0]   s_tdata,   // tick_time, sig_numerator, sig_denominator_log2,
                                   // clocks_per_click, zero pad
  input  logic [1:0]    s_tuser,   // opcode
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,   // measure_number, beat_number, scaled_tick,
                                   // pre_bar_offset, range_start, range_end, zero pad
  output logic [2:0]    m_tuser,   // status
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [30:0]   cfg_data
);

`include "assert_macros.svh"

  localparam int TW  = mbt_pkg::TICK_W;
  localparam int IW  = mbt_pkg::SEG_IDX_W;
  localparam int CW  = mbt_pkg::SEG_CNT_W;
  localparam int DW  = mbt_pkg::DIV_W;
  localparam int VW  = mbt_pkg::DVS_W;
  localparam int MW  = mbt_pkg::MEAS_W;
  localparam int BLW = mbt_pkg::BEAT_LEN_W;
  localparam int MLW = mbt_pkg::MEAS_LEN_W;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_EV_LEN = 12'b000000000010,
    S_EV_BT  = 12'b000000000100,
    S_EV_CHK = 12'b000000001000,
    S_EV_APP = 12'b000000010000,
    S_Q_SCAN = 12'b000000100000,
    S_Q_CHK  = 12'b000001000000,
    S_Q_MEAS = 12'b000010000000,
    S_Q_BEAT = 12'b000100000000,
    S_Q_TICK = 12'b001000000000,
    S_PRE    = 12'b010000000000,
    S_FINISH = 12'b100000000000
  } state_t;

  state_t state;

  // configuration
  logic [mbt_pkg::TPQ_W-1:0] tpq;
  logic [TW-1:0]             offset;

  // segment table
  logic [TW-1:0]  seg_start   [mbt_pkg::MAX_SEGMENTS];
  logic [MW-1:0]  seg_fm      [mbt_pkg::MAX_SEGMENTS];
  logic [BLW-1:0] seg_bt      [mbt_pkg::MAX_SEGMENTS];
  logic [MLW-1:0] seg_mt      [mbt_pkg::MAX_SEGMENTS];
  logic [CW-1:0]  seg_count;
  logic [IW-1:0]  rd_idx;

  // latched item
  logic [TW-1:0]              tick_r;
  logic [mbt_pkg::NUM_W-1:0]  num_r;
  logic [mbt_pkg::DLOG_W-1:0] dl_r;
  logic [mbt_pkg::CPC_W-1:0]  cpc_r;

  // event and query working registers
  logic [BLW-1:0] ev_bt;
  logic [MLW-1:0] ev_mt;
  logic [TW-1:0]  k_start;
  logic [MW-1:0]  k_fm;
  logic [BLW-1:0] k_bt;
  logic [MLW-1:0] k_mt;
  logic           has_next;
  logic [TW-1:0]  next_start;

  // result being built and result register
  mbt_pkg::status_t        w_status;
  logic [MW-1:0]           w_meas;
  logic [7:0]              w_beat;
  logic [15:0]             w_tk;
  logic [31:0]             w_pre;
  logic [TW-1:0]           w_rs;
  logic [TW-1:0]           w_re;
  logic [143:0]            out_data;
  logic [2:0]              out_user;

  mbt_pkg::div_req_t div_req;
  mbt_pkg::div_rsp_t div_rsp;

  mbt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // input fields
  mbt_pkg::opcode_t in_op;
  logic [TW-1:0]    in_tick;
  assign in_op   = mbt_pkg::opcode_t'(s_tuser);
  assign in_tick = s_tdata[30:0];

  // table reads
  logic [TW-1:0]  rd_start;
  logic [MW-1:0]  rd_fm;
  logic [MLW-1:0] rd_mt;
  logic [IW-1:0]  last_idx;
  logic [TW-1:0]  pre_diff;
  assign rd_start = seg_start[rd_idx];
  assign rd_fm    = seg_fm[rd_idx];
  assign rd_mt    = seg_mt[rd_idx];
  assign last_idx = IW'(seg_count - 1'b1);
  assign pre_diff = seg_start[0] - in_tick;

  // segment lengths from the current resolution
  logic [MLW-1:0] tpq_x4;
  logic [MLW-1:0] mt_prod;
  assign tpq_x4  = MLW'(tpq) * MLW'(mbt_pkg::QUARTERS_PER_WHOLE);
  assign mt_prod = tpq_x4 * MLW'(num_r);

  // arithmetic on divider results
  logic [DW:0]   app_sum;
  logic [DW:0]   q_sum;
  logic [TW-1:0] q_rs;
  logic [TW:0]   q_en;
  logic [TW:0]   q_en_clip;
  logic [DW-1:0] tk_mul;
  logic [31:0]   pre_mag;
  assign app_sum = (DW+1)'(rd_fm) + (DW+1)'(div_rsp.quotient)
                 + (DW+1)'(div_rsp.remainder != '0);
  assign q_sum   = (DW+1)'(k_fm) + (DW+1)'(div_rsp.quotient);
  assign q_rs    = tick_r - TW'(div_rsp.remainder);
  assign q_en    = {1'b0, q_rs} + (TW+1)'(k_mt);
  assign tk_mul  = DW'(div_rsp.remainder[BLW-1:0]) * DW'(mbt_pkg::INTERNAL_RES);
  assign pre_mag = (div_rsp.quotient > DW'(32'h8000_0000)) ? 32'h8000_0000
                                                           : div_rsp.quotient[31:0];

  // end of measure, clipped to next segment and to the tick range
  always_comb begin
    q_en_clip = q_en;
    if (has_next && q_en > {1'b0, next_start}) q_en_clip = {1'b0, next_start};
    if (q_en_clip > {1'b0, {TW{1'b1}}}) q_en_clip = {1'b0, {TW{1'b1}}};
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tpq    <= mbt_pkg::TPQ_W'(480);
      offset <= '0;
    end else if (cfg_we) begin
      if (cfg_index) offset <= cfg_data;
      else tpq <= cfg_data[mbt_pkg::TPQ_W-1:0];
    end
  end

  // sequencer, table and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      seg_count    <= CW'(1);
      seg_start[0] <= '0;
      seg_fm[0]    <= MW'(1);
      seg_bt[0]    <= BLW'(480);
      seg_mt[0]    <= MLW'(1920);
      rd_idx       <= '0;
      div_req      <= '0;
    end else begin
      div_req.start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            tick_r   <= in_tick;
            num_r    <= s_tdata[38:31];
            dl_r     <= s_tdata[41:39];
            cpc_r    <= s_tdata[49:42];
            w_status <= mbt_pkg::STS_OK;
            w_meas   <= '0;
            w_beat   <= '0;
            w_tk     <= '0;
            w_pre    <= '0;
            w_rs     <= '0;
            w_re     <= '0;
            state    <= S_FINISH;
            case (in_op)
              mbt_pkg::OP_CLEAR: begin
                seg_start[0] <= offset;
                seg_fm[0]    <= MW'(1);
                seg_bt[0]    <= BLW'(tpq);
                seg_mt[0]    <= tpq_x4;
                seg_count    <= CW'(1);
              end
              mbt_pkg::OP_EVENT: state <= S_EV_LEN;
              mbt_pkg::OP_QUERY: begin
                if (tpq == '0) begin
                  w_status <= mbt_pkg::STS_ZERO_LEN;
                end else if (in_tick < seg_start[0]) begin
                  div_req.start    <= 1'b1;
                  div_req.dividend <= DW'(pre_diff) * DW'(mbt_pkg::INTERNAL_RES);
                  div_req.divisor  <= VW'(tpq);
                  state            <= S_PRE;
                end else begin
                  rd_idx <= '0;
                  state  <= S_Q_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        // measure length by shift, beat length through the divider
        S_EV_LEN: begin
          ev_mt            <= mt_prod >> dl_r;
          div_req.start    <= 1'b1;
          div_req.dividend <= DW'(tpq) * DW'(cpc_r);
          div_req.divisor  <= VW'(mbt_pkg::CLOCKS_PER_QUARTER);
          state            <= S_EV_BT;
        end
        S_EV_BT: begin
          if (div_rsp.done) begin
            ev_bt <= div_rsp.quotient[BLW-1:0];
            if (div_rsp.quotient == '0 || ev_mt == '0) begin
              w_status <= mbt_pkg::STS_ZERO_LEN;
              state    <= S_FINISH;
            end else begin
              rd_idx <= last_idx;
              state  <= S_EV_CHK;
            end
          end
        end
        // overwrite, reject or start the measure count of a new segment
        S_EV_CHK: begin
          state <= S_FINISH;
          if (tick_r <= seg_start[0] || tick_r == rd_start) begin
            seg_bt[rd_idx] <= ev_bt;
            seg_mt[rd_idx] <= ev_mt;
          end else if (tick_r < rd_start) begin
            w_status <= mbt_pkg::STS_ORDER;
          end else if (seg_count >= CW'(mbt_pkg::MAX_SEGMENTS)) begin
            w_status <= mbt_pkg::STS_FULL;
          end else if (rd_mt == '0) begin
            w_status <= mbt_pkg::STS_ZERO_LEN;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= DW'(tick_r - rd_start);
            div_req.divisor  <= rd_mt;
            state            <= S_EV_APP;
          end
        end
        S_EV_APP: begin
          if (div_rsp.done) begin
            seg_start[seg_count[IW-1:0]] <= tick_r;
            seg_fm[seg_count[IW-1:0]]    <= (app_sum > (DW+1)'({MW{1'b1}}))
                                            ? {MW{1'b1}} : app_sum[MW-1:0];
            seg_bt[seg_count[IW-1:0]]    <= ev_bt;
            seg_mt[seg_count[IW-1:0]]    <= ev_mt;
            seg_count                    <= seg_count + 1'b1;
            state                        <= S_FINISH;
          end
        end
        // walk the segments, one a cycle, keeping the last that starts in time
        S_Q_SCAN: begin
          if (rd_idx == '0 || rd_start <= tick_r) begin
            k_start <= rd_start;
            k_fm    <= rd_fm;
            k_bt    <= seg_bt[rd_idx];
            k_mt    <= rd_mt;
            if (rd_idx == last_idx) begin
              has_next <= 1'b0;
              state    <= S_Q_CHK;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end else begin
            has_next   <= 1'b1;
            next_start <= rd_start;
            state      <= S_Q_CHK;
          end
        end
        S_Q_CHK: begin
          if (k_mt == '0 || k_bt == '0) begin
            w_status <= mbt_pkg::STS_ZERO_LEN;
            state    <= S_FINISH;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= DW'(tick_r - k_start);
            div_req.divisor  <= k_mt;
            state            <= S_Q_MEAS;
          end
        end
        // measures and bounds, then beat from the remainder
        S_Q_MEAS: begin
          if (div_rsp.done) begin
            w_meas <= (q_sum > (DW+1)'({MW{1'b1}})) ? {MW{1'b1}} : q_sum[MW-1:0];
            w_rs   <= q_rs;
            w_re   <= q_en_clip[TW-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= DW'(div_rsp.remainder);
            div_req.divisor  <= VW'(k_bt);
            state            <= S_Q_BEAT;
          end
        end
        S_Q_BEAT: begin
          if (div_rsp.done) begin
            w_beat <= (div_rsp.quotient >= DW'(255)) ? 8'd255
                                                     : div_rsp.quotient[7:0] + 8'd1;
            div_req.start    <= 1'b1;
            div_req.dividend <= tk_mul;
            div_req.divisor  <= VW'(tpq);
            state            <= S_Q_TICK;
          end
        end
        S_Q_TICK: begin
          if (div_rsp.done) begin
            w_tk  <= (div_rsp.quotient > DW'(16'hFFFF)) ? 16'hFFFF
                                                        : div_rsp.quotient[15:0];
            state <= S_FINISH;
          end
        end
        // scaled distance to measure one
        S_PRE: begin
          if (div_rsp.done) begin
            w_status <= mbt_pkg::STS_PRE_BAR;
            w_pre    <= 32'd0 - pre_mag;
            w_re     <= seg_start[0];
            state    <= S_FINISH;
          end
        end
        // hand the result to the output register once it is free
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_user <= w_status;
            out_data <= {6'd0, w_re, w_rs, w_pre, w_tk, w_beat, w_meas};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // states that wait on the divider, and the legal segment count
  logic div_wait;
  logic count_ok;
  assign div_wait = state inside {S_EV_BT, S_EV_APP, S_Q_MEAS, S_Q_BEAT, S_Q_TICK, S_PRE};
  assign count_ok = seg_count >= CW'(1) && seg_count <= CW'(mbt_pkg::MAX_SEGMENTS);

  // checks
  `ASSERT_ALWAYS(a_count_range, clk, rst, count_ok)
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPLIES(a_div_waited, clk, rst, div_rsp.done, div_wait)
  `ASSERT_IMPLIES(a_load_from_finish, clk, rst, $rose(m_tvalid), $past(state == S_FINISH))

endmodule

// ----- verif/measure_beat_tick_position_core_test.sv -----
`timescale 1ns / 1ps
module measure_beat_tick_position_core_test;

  localparam longint TICK_TOP = 64'h7FFF_FFFF;
  localparam longint MEAS_TOP = 1048575;

  typedef struct {
    mbt_pkg::status_t status;
    logic [19:0]      measure;
    logic [7:0]       beat;
    logic [15:0]      stick;
    logic [31:0]      pre_off;
    logic [30:0]      start_tick;
    logic [30:0]      end_tick;
  } position_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [143:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_we = 0;
  logic         cfg_index = 0;
  logic [30:0]  cfg_data = '0;

  measure_beat_tick_position_core dut (.*);

  // clock
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor copy of the registers and segment table
  longint res_q;
  longint bar_offset;
  longint seg_start[mbt_pkg::MAX_SEGMENTS];
  longint seg_meas[mbt_pkg::MAX_SEGMENTS];
  longint seg_beat[mbt_pkg::MAX_SEGMENTS];
  longint seg_bar[mbt_pkg::MAX_SEGMENTS];
  int     seg_n;

  position_t pending_pos[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_req_n = 0;
  int        hold_seen_n = 0;
  int        hold_left = 0;
  bit        failed = 0;

  function automatic void restart_table();
    for (int i = 0; i < mbt_pkg::MAX_SEGMENTS; i++) begin
      seg_start[i] = 0; seg_meas[i] = 0; seg_beat[i] = 0; seg_bar[i] = 0;
    end
    seg_start[0] = bar_offset;
    seg_meas[0]  = 1;
    seg_beat[0]  = res_q;
    seg_bar[0]   = res_q * 4;
    seg_n = 1;
  endfunction

  function automatic mbt_pkg::status_t apply_time_sig(longint t, longint num, int dl,
                                                      longint cpc);
    longint bt, mt, d, pm, m;
    int last;
    bt = res_q * cpc / mbt_pkg::CLOCKS_PER_QUARTER;
    mt = (res_q * mbt_pkg::QUARTERS_PER_WHOLE * num) >> dl;
    last = seg_n - 1;
    if (bt == 0 || mt == 0) return mbt_pkg::STS_ZERO_LEN;
    if (t <= seg_start[0] || t == seg_start[last]) begin
      seg_beat[last] = bt;
      seg_bar[last]  = mt;
      return mbt_pkg::STS_OK;
    end
    if (t < seg_start[last]) return mbt_pkg::STS_ORDER;
    if (seg_n >= mbt_pkg::MAX_SEGMENTS) return mbt_pkg::STS_FULL;
    if (seg_bar[last] == 0) return mbt_pkg::STS_ZERO_LEN;
    d  = t - seg_start[last];
    pm = seg_bar[last];
    m  = seg_meas[last] + (d + pm - 1) / pm;
    seg_start[seg_n] = t;
    seg_meas[seg_n]  = (m > MEAS_TOP) ? MEAS_TOP : m;
    seg_beat[seg_n]  = bt;
    seg_bar[seg_n]   = mt;
    seg_n++;
    return mbt_pkg::STS_OK;
  endfunction

  function automatic position_t locate_tick(longint t);
    position_t r;
    longint mag, mt, bt, d, q, rem, bn, tk, st, en;
    int k;
    r = '{mbt_pkg::STS_OK, 0, 0, 0, 0, 0, 0};
    if (res_q == 0) begin
      r.status = mbt_pkg::STS_ZERO_LEN;
      return r;
    end
    if (t < seg_start[0]) begin
      mag = (seg_start[0] - t) * mbt_pkg::INTERNAL_RES / res_q;
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      r.status   = mbt_pkg::STS_PRE_BAR;
      r.pre_off  = 32'(-mag);
      r.end_tick = 31'(seg_start[0]);
      return r;
    end
    k = 0;
    for (int i = 1; i < seg_n; i++) begin
      if (seg_start[i] > t) break;
      k = i;
    end
    mt = seg_bar[k];
    bt = seg_beat[k];
    if (mt == 0 || bt == 0) begin
      r.status = mbt_pkg::STS_ZERO_LEN;
      return r;
    end
    d   = t - seg_start[k];
    q   = d / mt;
    rem = d % mt;
    bn  = rem / bt + 1;
    tk  = (rem % bt) * mbt_pkg::INTERNAL_RES / res_q;
    st  = seg_start[k] + q * mt;
    en  = st + mt;
    if (k + 1 < seg_n && en > seg_start[k+1]) en = seg_start[k+1];
    if (en > TICK_TOP) en = TICK_TOP;
    q = q + seg_meas[k];
    r.measure    = 20'((q > MEAS_TOP) ? MEAS_TOP : q);
    r.beat       = 8'((bn > 255) ? 255 : bn);
    r.stick      = 16'((tk > 65535) ? 65535 : tk);
    r.start_tick = 31'(st);
    r.end_tick   = 31'(en);
    return r;
  endfunction

  function automatic position_t predict_item(mbt_pkg::opcode_t op, longint t, longint num,
                                             int dl, longint cpc);
    position_t r;
    r = '{mbt_pkg::STS_OK, 0, 0, 0, 0, 0, 0};
    case (op)
      mbt_pkg::OP_CLEAR: restart_table();
      mbt_pkg::OP_EVENT: r.status = apply_time_sig(t, num, dl, cpc);
      mbt_pkg::OP_QUERY: r = locate_tick(t);
      default: ;
    endcase
    return r;
  endfunction

  // one input transfer, predicted when accepted
  task automatic send_item(mbt_pkg::opcode_t op, logic [30:0] t, logic [7:0] num = 0,
                           logic [2:0] dl = 0, logic [7:0] cpc = 0);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, cpc, dl, num, t};
    do @(posedge clk); while (!s_tready);
    pending_pos.push_back(predict_item(op, t, num, dl, cpc));
  endtask

  // wait until every expected result is in, then let the block settle
  task automatic drain();
    int guard;
    s_tvalid <= 0;
    guard = 0;
    while (pending_pos.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, longint val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= 31'(val);
    @(posedge clk);
    cfg_we <= 0;
    if (idx == 0) res_q = val & 16'h7FFF;
    else bar_offset = val & TICK_TOP;
  endtask

  task automatic set_config(longint tpq, longint offs);
    drain();
    write_reg(0, tpq);
    write_reg(1, offs);
  endtask

  // receiver readiness, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req_n != hold_seen_n) begin
      hold_seen_n <= hold_req_n;
      hold_left   <= 400;
      m_tready    <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    position_t want;
    position_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status     = mbt_pkg::status_t'(m_tuser);
      got.measure    = m_tdata[19:0];
      got.beat       = m_tdata[27:20];
      got.stick      = m_tdata[43:28];
      got.pre_off    = m_tdata[75:44];
      got.start_tick = m_tdata[106:76];
      got.end_tick   = m_tdata[137:107];
      if (pending_pos.size() == 0) begin
        $error("result transfer with nothing expected");
        failed = 1;
      end else begin
        want = pending_pos.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); failed = 1;
        end
        if (got.measure !== want.measure) begin
          $error("measure_number: expected %0d, got %0d", want.measure, got.measure);
          failed = 1;
        end
        if (got.beat !== want.beat) begin
          $error("beat_number: expected %0d, got %0d", want.beat, got.beat); failed = 1;
        end
        if (got.stick !== want.stick) begin
          $error("scaled_tick: expected %0d, got %0d", want.stick, got.stick); failed = 1;
        end
        if (got.pre_off !== want.pre_off) begin
          $error("pre_bar_offset: expected %0d, got %0d", $signed(want.pre_off),
                 $signed(got.pre_off));
          failed = 1;
        end
        if (got.start_tick !== want.start_tick) begin
          $error("range_start: expected %0d, got %0d", want.start_tick, got.start_tick);
          failed = 1;
        end
        if (got.end_tick !== want.end_tick) begin
          $error("range_end: expected %0d, got %0d", want.end_tick, got.end_tick);
          failed = 1;
        end
      end
    end
  end

  // default table after reset, bar edges, the top tick and an unknown opcode
  task automatic test_reset_table();
    send_item(mbt_pkg::OP_QUERY, 0);
    send_item(mbt_pkg::OP_QUERY, 479);
    send_item(mbt_pkg::OP_QUERY, 480);
    send_item(mbt_pkg::OP_QUERY, 1919);
    send_item(mbt_pkg::OP_QUERY, 1920);
    send_item(mbt_pkg::OP_QUERY, 31'h7FFF_FFFF);
    send_item(mbt_pkg::OP_NONE, 31'h7FFF_FFFF, 8'hFF, 3'd7, 8'hFF);
  endtask

  // time-signature corner cases and a full table
  task automatic test_time_sig_cases();
    send_item(mbt_pkg::OP_EVENT, 100, 0, 2, 24);
    send_item(mbt_pkg::OP_EVENT, 100, 4, 2, 0);
    send_item(mbt_pkg::OP_EVENT, 0, 3, 2, 24);
    send_item(mbt_pkg::OP_EVENT, 1000, 255, 0, 255);
    send_item(mbt_pkg::OP_EVENT, 1000, 1, 7, 1);
    send_item(mbt_pkg::OP_EVENT, 500, 6, 3, 36);
    send_item(mbt_pkg::OP_QUERY, 999);
    send_item(mbt_pkg::OP_QUERY, 1000);
    for (int i = 1; i <= 16; i++) send_item(mbt_pkg::OP_EVENT, 1000 + i * 777, i, 2, 24);
    send_item(mbt_pkg::OP_QUERY, 5000);
    send_item(mbt_pkg::OP_QUERY, 31'h7FFF_FFFF);
    send_item(mbt_pkg::OP_CLEAR, 0);
  endtask

  // queries ahead of measure one and range saturation
  task automatic test_pre_bar();
    set_config(7, 1000000);
    send_item(mbt_pkg::OP_CLEAR, 0);
    send_item(mbt_pkg::OP_QUERY, 0);
    send_item(mbt_pkg::OP_QUERY, 999999);
    send_item(mbt_pkg::OP_QUERY, 1000000);
    set_config(1, 31'h7FFF_FFFF);
    send_item(mbt_pkg::OP_CLEAR, 0);
    send_item(mbt_pkg::OP_QUERY, 0);
    send_item(mbt_pkg::OP_EVENT, 5, 1, 0, 24);
    send_item(mbt_pkg::OP_QUERY, 31'h7FFF_FFFF);
    set_config(32767, 31'h7FFF_0000);
    send_item(mbt_pkg::OP_CLEAR, 0);
    send_item(mbt_pkg::OP_QUERY, 31'h7FFF_FFF0);
  endtask

  // mostly well-formed streams: rising event ticks, queries around the table
  task automatic run_random(int n, int clear_pct);
    int               pick, last;
    longint           t, span;
    mbt_pkg::opcode_t op;
    logic [7:0]       num, cpc;
    logic [2:0]       dl;
    for (int i = 0; i < n; i++) begin
      last = seg_n - 1;
      span = (seg_bar[last] > 0 ? seg_bar[last] : 1000) * $urandom_range(1, 6);
      pick = $urandom_range(99);
      if (pick < clear_pct) op = mbt_pkg::OP_CLEAR;
      else if (pick < clear_pct + 35) op = mbt_pkg::OP_EVENT;
      else if (pick < 98) op = mbt_pkg::OP_QUERY;
      else op = mbt_pkg::OP_NONE;
      num = ($urandom_range(9) < 8) ? 8'($urandom_range(1, 16)) : 8'($urandom);
      dl  = 3'($urandom);
      case ($urandom_range(4))
        0: cpc = 8'($urandom);
        1: cpc = 8'd12;
        2: cpc = 8'd36;
        default: cpc = 8'd24;
      endcase
      pick = $urandom_range(99);
      if (op == mbt_pkg::OP_EVENT) begin
        if (pick < 70) t = seg_start[last] + $urandom_range(0, 32'(span));
        else if (pick < 80) t = seg_start[0] - $urandom_range(0, 50);
        else if (pick < 95) t = seg_start[last] - $urandom_range(1, 5000);
        else t = $urandom;
      end else begin
        if (pick < 80) t = seg_start[0] - 200 + $urandom_range(0, 32'(span * 2 + 400));
        else t = $urandom;
      end
      if (t < 0) t = 0;
      if (t > TICK_TOP) t = TICK_TOP;
      send_item(op, 31'(t), num, dl, cpc);
    end
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_output_hold();
    drain();
    send_idle_pct = 0;
    hold_req_n++;
    run_random(20, 5);
  endtask

  task automatic test_random_phases();
    set_config(480, 0);
    send_item(mbt_pkg::OP_CLEAR, 0);
    run_random(200, 8);
    set_config($urandom_range(1, 32767), $urandom_range(0, 100000));
    send_item(mbt_pkg::OP_CLEAR, 0);
    run_random(175, 2);
    set_config(1, $urandom);
    send_item(mbt_pkg::OP_CLEAR, 0);
    run_random(100, 8);
    set_config(32767, 0);
    send_item(mbt_pkg::OP_CLEAR, 0);
    run_random(100, 6);
  endtask

  initial begin
    res_q = 480;
    bar_offset = 0;
    restart_table();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_table();
    test_time_sig_cases();
    test_pre_bar();
    send_idle_pct = 38; recv_idle_pct = 75;
    test_random_phases();
    send_idle_pct = 75; recv_idle_pct = 38;
    test_random_phases();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_config($urandom_range(100, 2000), $urandom_range(0, 5000));
    send_item(mbt_pkg::OP_CLEAR, 0);
    run_random(200, 3);
    test_output_hold();
    drain();
    if (!failed && pending_pos.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- measure_beat_tick_position_core.f -----
+incdir+design
design/mbt_pkg.sv
design/mbt_div.sv
design/measure_beat_tick_position_core.sv
verif/measure_beat_tick_position_core_test.sv
